// ----- src/baudot_ita2_shift_transcoder_macros.svh -----
// Assertion macros used by the transcoder top module.
`ifndef BAUDOT_ITA2_SHIFT_TRANSCODER_MACROS_SVH
`define BAUDOT_ITA2_SHIFT_TRANSCODER_MACROS_SVH

// Implication checked in the same cycle, sampled on clock, off during reset.
`define ITA2ST_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ITA2ST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ita2st_pkg.sv -----
// Types, constants and code tables of the teleprinter transcoder.
package ita2st_pkg;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ITA2_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT6_MODE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVOID_NULL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_VARIANT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNKNOWN_ASCII = 3'd4;

   localparam logic [1:0] VARIANT_US   = 2'd0;
   localparam logic [1:0] VARIANT_INTL = 2'd1;
   localparam logic [1:0] VARIANT_ES   = 2'd2;

   localparam logic [7:0] CODE_FIGS      = 8'd27;
   localparam logic [7:0] CODE_LTRS      = 8'd31;
   localparam logic [7:0] CHAR_MASK      = 8'b00011111;
   localparam logic [7:0] ECHO_FIGS      = 8'h0f;
   localparam logic [7:0] ECHO_LTRS      = 8'h0e;
   localparam logic [7:0] CHAR_CR        = 8'h0d;
   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CTRL_LAST      = 8'd31;
   localparam logic [7:0] LOWER_A        = 8'h61;
   localparam logic [7:0] LOWER_Z        = 8'h7a;
   localparam logic [7:0] CASE_OFFSET    = 8'd32;
   localparam logic [5:0] CODE_SPACE     = 6'd4;
   localparam logic [5:0] CODE_SPACE_FIG = 6'h24;
   localparam int         SHIFT_POS      = 5;

   localparam logic [7:0] CFG_RESET_UNKNOWN = 8'd63;

   typedef struct packed {
      logic       ita2_mode;
      logic       bit6_mode;
      logic       avoid_null;
      logic [1:0] table_variant;
      logic [7:0] unknown_ascii;
   } cfg_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_in;
      logic       test_only;
   } item_type;

   typedef struct packed {
      logic [7:0] code_out;
      logic       emit;
      logic       accepted;
      logic       printable;
      logic       shift_now;
      logic       last;
   } rsp_type;

   // Letters half, common to every variant.
   localparam logic [7:0] LTRS_HALF [0:31] = '{
      8'h00, 8'h45, 8'h0a, 8'h41, 8'h20, 8'h53, 8'h49, 8'h55,
      8'h0d, 8'h44, 8'h52, 8'h4a, 8'h4e, 8'h46, 8'h43, 8'h4b,
      8'h54, 8'h5a, 8'h4c, 8'h57, 8'h48, 8'h59, 8'h50, 8'h51,
      8'h4f, 8'h42, 8'h47, 8'h0f, 8'h4d, 8'h58, 8'h56, 8'h0e};

   localparam logic [7:0] FIGS_US [0:31] = '{
      8'h00, 8'h33, 8'h0a, 8'h2d, 8'h20, 8'h27, 8'h38, 8'h37,
      8'h0d, 8'h24, 8'h34, 8'h07, 8'h2c, 8'h21, 8'h3a, 8'h28,
      8'h35, 8'h22, 8'h29, 8'h32, 8'h23, 8'h36, 8'h30, 8'h31,
      8'h39, 8'h3f, 8'h26, 8'h0f, 8'h2e, 8'h2f, 8'h3b, 8'h0e};

   localparam logic [7:0] FIGS_INTL [0:31] = '{
      8'h00, 8'h33, 8'h0a, 8'h2d, 8'h20, 8'h27, 8'h38, 8'h37,
      8'h0d, 8'h05, 8'h34, 8'h07, 8'h2c, 8'h40, 8'h3a, 8'h28,
      8'h35, 8'h2b, 8'h29, 8'h32, 8'h24, 8'h36, 8'h30, 8'h31,
      8'h39, 8'h3f, 8'h2a, 8'h0f, 8'h2e, 8'h2f, 8'h3d, 8'h0e};

   localparam logic [7:0] FIGS_ES [0:31] = '{
      8'h00, 8'h33, 8'h0a, 8'h2d, 8'h20, 8'h27, 8'h38, 8'h37,
      8'h0d, 8'h05, 8'h34, 8'h07, 8'h2c, 8'h24, 8'h3a, 8'h28,
      8'h35, 8'h2b, 8'h29, 8'h32, 8'ha5, 8'h36, 8'h30, 8'h31,
      8'h39, 8'h3f, 8'h2a, 8'h0f, 8'h2e, 8'h2f, 8'h3d, 8'h0e};

   // Figures half entry; the unused variant code falls back to international.
   function automatic logic [7:0] figs_entry(input logic [1:0] variant,
                                             input logic [4:0] idx);
      logic [7:0] ch;
      unique case (variant)
         VARIANT_US: ch = FIGS_US[idx];
         VARIANT_ES: ch = FIGS_ES[idx];
         default:    ch = FIGS_INTL[idx];
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] table_entry(input logic [1:0] variant,
                                              input logic [5:0] idx);
      logic [7:0] ch;
      if (idx[SHIFT_POS]) begin
         ch = figs_entry(variant, idx[4:0]);
      end else begin
         ch = LTRS_HALF[idx[4:0]];
      end
      return ch;
   endfunction

   // Reverse lookup. Entries are distinct within each half, so the match in
   // a half is one-hot and its index is an OR over the compares. The shift
   // decides which half wins when a character sits in both.
   function automatic logic [5:0] enc_index(input logic [7:0] ch_in,
                                            input logic [1:0] variant,
                                            input logic       figs);
      logic [7:0] ch;
      logic [4:0] lidx;
      logic [4:0] fidx;
      logic       lhit;
      logic       fhit;
      logic [5:0] idx;
      ch   = ch_in;
      lidx = '0;
      fidx = '0;
      lhit = 1'b0;
      fhit = 1'b0;
      if (ch >= LOWER_A && ch <= LOWER_Z) begin
         ch = ch - CASE_OFFSET;
      end
      for (int i = 0; i < 32; i++) begin
         if (LTRS_HALF[i] == ch) begin
            lidx = lidx | 5'(i);
            lhit = 1'b1;
         end
         if (figs_entry(variant, 5'(i)) == ch) begin
            fidx = fidx | 5'(i);
            fhit = 1'b1;
         end
      end
      if (figs) begin
         // A letters-half match at index zero is not taken in figures shift.
         if (fhit) begin
            idx = {1'b1, fidx};
         end else if (lhit && lidx != 5'd0) begin
            idx = {1'b0, lidx};
         end else begin
            idx = CODE_SPACE_FIG;
         end
      end else begin
         if (lhit) begin
            idx = {1'b0, lidx};
         end else if (fhit) begin
            idx = {1'b1, fidx};
         end else begin
            idx = CODE_SPACE;
         end
      end
      return idx;
   endfunction

endpackage

// ----- src/ita2st_xlate.sv -----
// Translation logic for one result: encode pass or decode, with shift update.
module ita2st_xlate (
   input  ita2st_pkg::cfg_type  cfg,
   input  ita2st_pkg::item_type item,
   input  logic                 figs,
   input  logic                 second_pass,
   output ita2st_pkg::rsp_type  rsp,
   output logic                 figs_next
);
   import ita2st_pkg::*;

   logic [7:0] enc_v;
   logic       enc_adv;
   logic [7:0] dec_v;
   logic       dec_general;

   always_comb begin
      enc_v       = '0;
      enc_adv     = 1'b1;
      dec_v       = '0;
      dec_general = 1'b1;
      figs_next   = figs;
      rsp         = '0;
      rsp.accepted = 1'b1;
      rsp.last     = 1'b1;

      if (!item.cmd) begin
         if (cfg.ita2_mode) begin
            enc_v = {2'b00, enc_index(item.char_in, cfg.table_variant, figs)};
         end else begin
            enc_v = item.char_in;
         end
         if (cfg.bit6_mode) begin
            // A shift change goes out first; the character follows next pass.
            if (enc_v[SHIFT_POS]) begin
               if (!figs) begin
                  enc_v   = CODE_FIGS;
                  enc_adv = 1'b0;
               end
            end else if (figs) begin
               enc_v   = CODE_LTRS;
               enc_adv = 1'b0;
            end
         end else begin
            enc_v = enc_v & CHAR_MASK;
         end
         if (second_pass) begin
            enc_adv = 1'b1;
         end
         if (enc_v == CODE_LTRS) begin
            figs_next = 1'b0;
         end else if (enc_v == CODE_FIGS) begin
            figs_next = 1'b1;
         end
         rsp.code_out = enc_v;
         rsp.emit     = 1'b1;
         rsp.last     = enc_adv;
      end else begin
         if (cfg.ita2_mode) begin
            if (item.char_in == CODE_FIGS) begin
               figs_next    = 1'b1;
               rsp.code_out = ECHO_FIGS;
               dec_general  = 1'b0;
            end else if (item.char_in == CODE_LTRS) begin
               figs_next    = 1'b0;
               rsp.code_out = ECHO_LTRS;
               dec_general  = 1'b0;
            end else if (item.char_in[7:6] != 2'b00) begin
               if (cfg.avoid_null) begin
                  dec_general = 1'b0;
               end else begin
                  dec_v = cfg.unknown_ascii;
               end
            end else begin
               dec_v = table_entry(cfg.table_variant,
                                   {item.char_in[5] | figs, item.char_in[4:0]});
            end
         end else begin
            dec_v = item.char_in;
         end
         if (dec_general) begin
            rsp.code_out = dec_v;
            if (dec_v != 8'd0 || !cfg.avoid_null) begin
               rsp.printable = (dec_v > CTRL_LAST) || (dec_v == CHAR_CR) ||
                               (dec_v == CHAR_LF);
               rsp.emit      = !item.test_only;
            end else begin
               rsp.accepted = 1'b0;
            end
         end
      end
      rsp.shift_now = figs_next;
   end

endmodule

// ----- src/baudot_ita2_shift_transcoder.sv -----
// A request is held in the input register and its result is presented from the
// output register. Throughput: one result per cycle through the single
// translation path while the output is free; an encode that first needs a FIGS
// or LTRS code holds its request for a second pass that yields the character.
// Reset (synchronous): shift is letters, both registers empty, CSRs at defaults.
`include "baudot_ita2_shift_transcoder_macros.svh"

module baudot_ita2_shift_transcoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [7:0]                       req_char_in,
   input  logic                             req_test_only,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_code_out,
   output logic                             rsp_emit,
   output logic                             rsp_accepted,
   output logic                             rsp_printable,
   output logic                             rsp_shift_now,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ita2st_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                       csr_data
);
   import ita2st_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     fs_ff, fs_in;
   logic     in_valid_ff, in_valid_in;
   item_type item_ff, item_in;
   logic     pass_ff, pass_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   rsp_type  xl_rsp;
   logic     xl_figs_next;
   logic     out_free;
   logic     fire;
   logic     req_take;

   ita2st_xlate u_xlate (
      .cfg         (cfg_ff),
      .item        (item_ff),
      .figs        (fs_ff),
      .second_pass (pass_ff),
      .rsp         (xl_rsp),
      .figs_next   (xl_figs_next)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || (fire && xl_rsp.last);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ITA2_MODE:     cfg_in.ita2_mode     = csr_data[0];
            CSR_BIT6_MODE:     cfg_in.bit6_mode     = csr_data[0];
            CSR_AVOID_NULL:    cfg_in.avoid_null    = csr_data[0];
            CSR_TABLE_VARIANT: cfg_in.table_variant = csr_data[1:0];
            CSR_UNKNOWN_ASCII: cfg_in.unknown_ascii = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      pass_in     = pass_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         item_in     = '{cmd: req_cmd, char_in: req_char_in, test_only: req_test_only};
         pass_in     = 1'b0;
      end else if (fire) begin
         // A shift code leaves the request in place for its character pass.
         in_valid_in = !xl_rsp.last;
         pass_in     = !xl_rsp.last;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fs_in        = fs_ff;
      if (fire) begin
         rsp_in       = xl_rsp;
         rsp_valid_in = 1'b1;
         fs_in        = xl_figs_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{ita2_mode: 1'b1, bit6_mode: 1'b0, avoid_null: 1'b0,
                           table_variant: VARIANT_INTL, unknown_ascii: CFG_RESET_UNKNOWN};
         fs_ff        <= 1'b0;
         in_valid_ff  <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         fs_ff        <= fs_in;
         in_valid_ff  <= in_valid_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_out  = rsp_ff.code_out;
   assign rsp_emit      = rsp_ff.emit;
   assign rsp_accepted  = rsp_ff.accepted;
   assign rsp_printable = rsp_ff.printable;
   assign rsp_shift_now = rsp_ff.shift_now;
   assign rsp_last      = rsp_ff.last;

   `ITA2ST_ASSERT_SAME(a_first_is_shift, rsp_valid_ff && !rsp_ff.last,
      rsp_ff.code_out == CODE_FIGS || rsp_ff.code_out == CODE_LTRS,
      "non-final result is not a shift code")
   `ITA2ST_ASSERT_NEXT(a_second_follows, rsp_valid_ff && rsp_ready && !rsp_ff.last,
      rsp_valid_ff, "character result did not follow its shift code")
   `ITA2ST_ASSERT_SAME(a_emit_accepted, rsp_valid_ff && rsp_ff.emit,
      rsp_ff.accepted, "emitted result not marked accepted")
   `ITA2ST_ASSERT_SAME(a_shift_tracks, rsp_valid_ff, rsp_ff.shift_now == fs_ff,
      "presented shift flag differs from shift state")

endmodule
